/* hdl/lssp_pkg.sv */
// Shared types and constants for the line/segment split point pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package lssp_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Coordinate and intermediate widths (all signed unless noted)
    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;        // p2 - p1, p1 - origin
    localparam int PDEN_W  = COORD_W + DIFF_W;   // dir * e
    localparam int PNUM_W  = 2 * DIFF_W;         // (p1 - o) * e, e * e
    localparam int DEN_W   = PDEN_W + 1;
    localparam int NUM_W   = PNUM_W + 1;
    localparam int DOT_W   = PNUM_W + 1;
    localparam int DMAG_W  = 64;                 // |den| < 2^64, unsigned
    localparam int NMAG_W  = 65;                 // |num| < 2^65, unsigned

    // Quotient bits resolved by the divider chain: QUOT_BASE + FRAC_BITS.
    // Larger quotients clamp; the point saturates the same way.
    localparam int QUOT_BASE = 34;

    localparam logic signed [COORD_W-1:0] COORD_MAX   = 32'sh7fff_ffff;
    localparam logic signed [COORD_W-1:0] COORD_MIN   = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] DIR_X_RESET = 32'sh0001_0000;

    // Configuration register indexes
    localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] CFG_DIR_X    = 2'd2;
    localparam logic [1:0] CFG_DIR_Y    = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic signed [COORD_W-1:0] dx;
        logic signed [COORD_W-1:0] dy;
    } t_line;

    // Per-transaction sideband that travels with the pipeline
    typedef struct packed {
        logic                      vld;
        logic                      par;   // zero denominator
        logic                      tneg;  // quotient sign
        logic                      ovf;   // quotient beyond divider range
        logic signed [COORD_W-1:0] p1x;
        logic signed [COORD_W-1:0] p1y;
        logic signed [DIFF_W-1:0]  ex;
        logic signed [DIFF_W-1:0]  ey;
        logic signed [DOT_W-1:0]   ee;
    } t_side;

endpackage

`default_nettype wire

/* hdl/lssp_front.sv */
// Front end: edge vectors, cross products, magnitudes and divider setup.
// Depends on lssp_pkg.
`default_nettype none

module lssp_front #(
    parameter int FRAC_BITS = lssp_pkg::FRAC_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  lssp_pkg::t_line                              i_line,
    input  logic                                         i_start,
    input  logic signed [lssp_pkg::COORD_W-1:0]          i_p1_x,
    input  logic signed [lssp_pkg::COORD_W-1:0]          i_p1_y,
    input  logic signed [lssp_pkg::COORD_W-1:0]          i_p2_x,
    input  logic signed [lssp_pkg::COORD_W-1:0]          i_p2_y,
    output lssp_pkg::t_side                              o_side,
    output logic [lssp_pkg::DMAG_W-1:0]                  o_rem,
    output logic [lssp_pkg::DMAG_W-1:0]                  o_den,
    output logic [lssp_pkg::QUOT_BASE+FRAC_BITS-1:0]     o_nq
);
    import lssp_pkg::*;

    localparam int QB    = QUOT_BASE + FRAC_BITS;
    localparam int NS_W  = NMAG_W + FRAC_BITS;
    localparam int TOP_W = NS_W - QB;

    t_side r_s1, r_s2, r_s3, r_s4, r_s5;
    t_side n_s1, n_s3, n_s4, n_s5;

    logic signed [DIFF_W-1:0] r_ax, r_ay;
    logic signed [PDEN_W-1:0] r_pda, r_pdb;
    logic signed [PNUM_W-1:0] r_pna, r_pnb, r_pex, r_pey;
    logic signed [DEN_W-1:0]  r_den;
    logic signed [NUM_W-1:0]  r_num;
    logic [DMAG_W-1:0]        r_dmag, r_dv, r_rem;
    logic [NMAG_W-1:0]        r_nmag;
    logic [QB-1:0]            r_nq;

    logic [NS_W-1:0]          w_nsh;
    logic [TOP_W-1:0]         w_top;

    always_comb begin
        n_s1      = '0;
        n_s1.vld  = i_start;
        n_s1.p1x  = i_p1_x;
        n_s1.p1y  = i_p1_y;
        n_s1.ex   = DIFF_W'(i_p2_x) - DIFF_W'(i_p1_x);
        n_s1.ey   = DIFF_W'(i_p2_y) - DIFF_W'(i_p1_y);
    end

    always_comb begin
        n_s3      = r_s2;
        n_s3.ee   = DOT_W'(r_pex) + DOT_W'(r_pey);
        n_s4      = r_s3;
        n_s4.par  = (r_den == '0);
        n_s4.tneg = r_num[NUM_W-1] ^ r_den[DEN_W-1];
    end

    // Quotient fits QB bits exactly when the top numerator bits stay below |den|
    always_comb begin
        w_nsh    = NS_W'(r_nmag) << FRAC_BITS;
        w_top    = w_nsh[NS_W-1:QB];
        n_s5     = r_s4;
        n_s5.ovf = (DMAG_W'(w_top) >= r_dmag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
            r_s4 <= '0;
            r_s5 <= '0;
        end else begin
            r_s1 <= n_s1;
            r_s2 <= r_s1;
            r_s3 <= n_s3;
            r_s4 <= n_s4;
            r_s5 <= n_s5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax   <= DIFF_W'(i_p1_x) - DIFF_W'(i_line.ox);
        r_ay   <= DIFF_W'(i_p1_y) - DIFF_W'(i_line.oy);

        r_pda  <= PDEN_W'(i_line.dy) * PDEN_W'(r_s1.ex);
        r_pdb  <= PDEN_W'(i_line.dx) * PDEN_W'(r_s1.ey);
        r_pna  <= PNUM_W'(r_ay) * PNUM_W'(r_s1.ex);
        r_pnb  <= PNUM_W'(r_ax) * PNUM_W'(r_s1.ey);
        r_pex  <= PNUM_W'(r_s1.ex) * PNUM_W'(r_s1.ex);
        r_pey  <= PNUM_W'(r_s1.ey) * PNUM_W'(r_s1.ey);

        r_den  <= DEN_W'(r_pda) - DEN_W'(r_pdb);
        r_num  <= NUM_W'(r_pna) - NUM_W'(r_pnb);

        r_dmag <= r_den[DEN_W-1] ? DMAG_W'(-r_den) : DMAG_W'(r_den);
        r_nmag <= r_num[NUM_W-1] ? NMAG_W'(-r_num) : NMAG_W'(r_num);

        r_rem  <= DMAG_W'(w_top);
        r_dv   <= r_dmag;
        r_nq   <= w_nsh[QB-1:0];
    end

    assign o_side = r_s5;
    assign o_rem  = r_rem;
    assign o_den  = r_dv;
    assign o_nq   = r_nq;

endmodule

`default_nettype wire

/* hdl/lssp_div_cell.sv */
// One restoring-division cell: resolves one quotient bit and passes on.
// Depends on lssp_pkg.
`default_nettype none

module lssp_div_cell #(
    parameter int FRAC_BITS = lssp_pkg::FRAC_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  lssp_pkg::t_side                              i_side,
    input  logic [lssp_pkg::DMAG_W-1:0]                  i_rem,
    input  logic [lssp_pkg::DMAG_W-1:0]                  i_den,
    input  logic [lssp_pkg::QUOT_BASE+FRAC_BITS-1:0]     i_nq,
    output lssp_pkg::t_side                              o_side,
    output logic [lssp_pkg::DMAG_W-1:0]                  o_rem,
    output logic [lssp_pkg::DMAG_W-1:0]                  o_den,
    output logic [lssp_pkg::QUOT_BASE+FRAC_BITS-1:0]     o_nq
);
    import lssp_pkg::*;

    localparam int QB = QUOT_BASE + FRAC_BITS;

    t_side             r_side;
    logic [DMAG_W-1:0] r_rem, r_den;
    logic [QB-1:0]     r_nq;

    logic [DMAG_W:0]   w_trial;
    logic [DMAG_W+1:0] w_diff;
    logic              w_ge;

    // nq holds the unread numerator bits on top and quotient bits below
    always_comb begin
        w_trial = {i_rem, i_nq[QB-1]};
        w_diff  = {1'b0, w_trial} - {2'b00, i_den};
        w_ge    = !w_diff[DMAG_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= w_ge ? w_diff[DMAG_W-1:0] : w_trial[DMAG_W-1:0];
        r_den <= i_den;
        r_nq  <= {i_nq[QB-2:0], w_ge};
    end

    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_nq   = r_nq;

endmodule

`default_nettype wire

/* hdl/lssp_post.sv */
// Back end: signed quotient, point on the line, saturation and hit test.
// Depends on lssp_pkg.
`default_nettype none

module lssp_post #(
    parameter int FRAC_BITS = lssp_pkg::FRAC_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  lssp_pkg::t_line                              i_line,
    input  lssp_pkg::t_side                              i_side,
    input  logic [lssp_pkg::QUOT_BASE+FRAC_BITS-1:0]     i_nq,
    output logic                                         o_valid,
    output logic                                         o_hit,
    output logic signed [lssp_pkg::COORD_W-1:0]          o_split_x,
    output logic signed [lssp_pkg::COORD_W-1:0]          o_split_y
);
    import lssp_pkg::*;

    localparam int QB       = QUOT_BASE + FRAC_BITS;
    localparam int TW       = QB + 1;
    localparam int TH       = TW - COORD_W;
    localparam int PL_W     = 2 * COORD_W + 1;
    localparam int PH_W     = COORD_W + TH;
    localparam int PW       = PH_W + COORD_W;
    localparam int SH_W     = PW - FRAC_BITS;
    localparam int SUM_W    = SH_W + 1;
    localparam int P_STAGES = 6;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(COORD_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(COORD_MIN);

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [SUM_W-1:0] s
    );
        logic signed [COORD_W-1:0] r;
        if (s > SUM_MAX) begin
            r = COORD_MAX;
        end else if (s < SUM_MIN) begin
            r = COORD_MIN;
        end else begin
            r = s[COORD_W-1:0];
        end
        return r;
    endfunction

    t_side r_side [P_STAGES];

    logic signed [TW-1:0]      r_t, n_t;
    logic [QB-1:0]             w_qmag;
    logic signed [PL_W-1:0]    r_plx, r_ply;
    logic signed [PH_W-1:0]    r_phx, r_phy;
    logic signed [PW-1:0]      r_fx, r_fy;
    logic signed [COORD_W-1:0] r_px, r_py;
    logic signed [DIFF_W-1:0]  r_rx, r_ry;
    logic signed [PNUM_W-1:0]  r_mx, r_my;
    logic signed [SUM_W-1:0]   w_sx, w_sy;
    logic signed [DOT_W-1:0]   w_dot;
    logic                      w_hit;

    logic                      r_valid, r_hit;
    logic signed [COORD_W-1:0] r_ox, r_oy;
    logic signed [COORD_W-1:0] r_px_d1, r_py_d1, r_px_d, r_py_d;

    // Out-of-range quotients clamp to the largest magnitude the chain resolves
    always_comb begin
        w_qmag = i_side.ovf ? '1 : i_nq;
        n_t    = {1'b0, w_qmag};
        if (i_side.tneg) begin
            n_t = -n_t;
        end
    end

    always_comb begin
        w_sx  = SUM_W'($signed(r_fx[PW-1:FRAC_BITS])) + SUM_W'(i_line.ox);
        w_sy  = SUM_W'($signed(r_fy[PW-1:FRAC_BITS])) + SUM_W'(i_line.oy);
        w_dot = DOT_W'(r_mx) + DOT_W'(r_my);
        w_hit = !w_dot[DOT_W-1] && !(r_side[P_STAGES-1].ee < w_dot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < P_STAGES; i++) begin
                r_side[i] <= '0;
            end
            r_valid <= 1'b0;
        end else begin
            r_side[0] <= i_side;
            for (int i = 1; i < P_STAGES; i++) begin
                r_side[i] <= r_side[i-1];
            end
            r_valid <= r_side[P_STAGES-1].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t   <= n_t;

        // direction * t from two partial products: unsigned low word, signed high
        r_plx <= PL_W'(i_line.dx) * PL_W'($signed({1'b0, r_t[COORD_W-1:0]}));
        r_ply <= PL_W'(i_line.dy) * PL_W'($signed({1'b0, r_t[COORD_W-1:0]}));
        r_phx <= PH_W'(i_line.dx) * PH_W'($signed(r_t[TW-1:COORD_W]));
        r_phy <= PH_W'(i_line.dy) * PH_W'($signed(r_t[TW-1:COORD_W]));

        r_fx  <= (PW'(r_phx) <<< COORD_W) + PW'(r_plx);
        r_fy  <= (PW'(r_phy) <<< COORD_W) + PW'(r_ply);

        r_px  <= sat_coord(w_sx);
        r_py  <= sat_coord(w_sy);

        r_rx  <= DIFF_W'(r_px) - DIFF_W'(r_side[3].p1x);
        r_ry  <= DIFF_W'(r_py) - DIFF_W'(r_side[3].p1y);

        r_mx  <= PNUM_W'(r_rx) * PNUM_W'(r_side[4].ex);
        r_my  <= PNUM_W'(r_ry) * PNUM_W'(r_side[4].ey);

        r_hit <= r_side[P_STAGES-1].par ? 1'b0 : w_hit;
        r_ox  <= r_side[P_STAGES-1].par ? '0 : r_px_d;
        r_oy  <= r_side[P_STAGES-1].par ? '0 : r_py_d;
    end

    // point delayed to line up with the dot product stage
    always_ff @(posedge i_clk) begin
        r_px_d1 <= r_px;
        r_py_d1 <= r_py;
        r_px_d  <= r_px_d1;
        r_py_d  <= r_py_d1;
    end

    assign o_valid   = r_valid;
    assign o_hit     = r_hit;
    assign o_split_x = r_ox;
    assign o_split_y = r_oy;

endmodule

`default_nettype wire

/* hdl/line_segment_split_point.sv */
// Line/segment split point: fully pipelined, one transaction per cycle.
// From start to o_valid: the divider chain of 34 + FRAC_BITS cells plus
// 12 arithmetic stages in the front and back ends.
// Throughput: one segment per clock; busy stays low, results cannot stall.
// Synchronous active-low reset clears pipeline valids and loads the line
// registers with origin (0, 0) and direction (1.0, 0).
`default_nettype none

module line_segment_split_point #(
    parameter int FRAC_BITS = lssp_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [lssp_pkg::COORD_W-1:0] i_p1_x,
    input  logic signed [lssp_pkg::COORD_W-1:0] i_p1_y,
    input  logic signed [lssp_pkg::COORD_W-1:0] i_p2_x,
    input  logic signed [lssp_pkg::COORD_W-1:0] i_p2_y,
    output logic                                o_valid,
    output logic                                o_hit,
    output logic signed [lssp_pkg::COORD_W-1:0] o_split_x,
    output logic signed [lssp_pkg::COORD_W-1:0] o_split_y,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_index,
    input  logic [lssp_pkg::COORD_W-1:0]        i_cfg_data
);
    import lssp_pkg::*;

    localparam int QB = QUOT_BASE + FRAC_BITS;

    t_line r_line, n_line;

    t_side             w_side [QB+1];
    logic [DMAG_W-1:0] w_rem  [QB+1];
    logic [DMAG_W-1:0] w_den  [QB+1];
    logic [QB-1:0]     w_nq   [QB+1];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_line = r_line;
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X: n_line.ox = $signed(i_cfg_data);
                CFG_ORIGIN_Y: n_line.oy = $signed(i_cfg_data);
                CFG_DIR_X:    n_line.dx = $signed(i_cfg_data);
                CFG_DIR_Y:    n_line.dy = $signed(i_cfg_data);
                default:      n_line    = r_line;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line.ox <= '0;
            r_line.oy <= '0;
            r_line.dx <= DIR_X_RESET;
            r_line.dy <= '0;
        end else begin
            r_line <= n_line;
        end
    end

    lssp_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (r_line),
        .i_start (start && !busy),
        .i_p1_x  (i_p1_x),
        .i_p1_y  (i_p1_y),
        .i_p2_x  (i_p2_x),
        .i_p2_y  (i_p2_y),
        .o_side  (w_side[0]),
        .o_rem   (w_rem[0]),
        .o_den   (w_den[0]),
        .o_nq    (w_nq[0])
    );

    // quotient bits resolve MSB first, one per cell
    for (genvar k = 0; k < QB; k++) begin : g_cell
        lssp_div_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_side  (w_side[k]),
            .i_rem   (w_rem[k]),
            .i_den   (w_den[k]),
            .i_nq    (w_nq[k]),
            .o_side  (w_side[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_den   (w_den[k+1]),
            .o_nq    (w_nq[k+1])
        );
    end

    lssp_post #(
        .FRAC_BITS (FRAC_BITS)
    ) u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_line    (r_line),
        .i_side    (w_side[QB]),
        .i_nq      (w_nq[QB]),
        .o_valid   (o_valid),
        .o_hit     (o_hit),
        .o_split_x (o_split_x),
        .o_split_y (o_split_y)
    );

endmodule

`default_nettype wire

/* test/line_segment_split_point_tb.sv */
// Self-checking bench for line_segment_split_point: segments stream through the pipeline
// and each result is checked against a 128-bit integer model of the split point and hit.
// Depends on lssp_pkg and the line_segment_split_point RTL only.
module line_segment_split_point_tb;
    import lssp_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int LATENCY     = 46 + FRAC;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 115;
    localparam int NEAR_SPAN   = 1 << 20;

    localparam logic signed [COORD_W-1:0] ONE    = 32'sh0001_0000;
    localparam logic signed [127:0]       SAT_LO = COORD_MIN;
    localparam logic signed [127:0]       SAT_HI = COORD_MAX;

    typedef struct packed {
        logic signed [COORD_W-1:0] p1x;
        logic signed [COORD_W-1:0] p1y;
        logic signed [COORD_W-1:0] p2x;
        logic signed [COORD_W-1:0] p2y;
    } t_segment;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
    } t_split;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic signed [COORD_W-1:0] i_p1_x = '0;
    logic signed [COORD_W-1:0] i_p1_y = '0;
    logic signed [COORD_W-1:0] i_p2_x = '0;
    logic signed [COORD_W-1:0] i_p2_y = '0;
    logic                      o_valid;
    logic                      o_hit;
    logic signed [COORD_W-1:0] o_split_x;
    logic signed [COORD_W-1:0] o_split_y;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [1:0]                i_cfg_index = CFG_ORIGIN_X;
    logic [COORD_W-1:0]        i_cfg_data = '0;

    // shadow of the line registers, reset values
    t_line    line_now = '{ox: '0, oy: '0, dx: DIR_X_RESET, dy: '0};
    t_segment segments_pending[$];
    t_split   splits_expected[$];

    int  segments_queued = 0;
    int  segments_sent = 0;
    int  splits_checked = 0;
    int  hits_seen = 0;
    int  line_settings = 0;
    int  failures = 0;
    int  cycles = 0;
    int  burst_left = 1;
    int  gap_left = 0;
    logic drain_hold = 1'b0;
    logic seg_taken = 1'b0;

    line_segment_split_point i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_p1_x      (i_p1_x),
        .i_p1_y      (i_p1_y),
        .i_p2_x      (i_p2_x),
        .i_p2_y      (i_p2_y),
        .o_valid     (o_valid),
        .o_hit       (o_hit),
        .o_split_x   (o_split_x),
        .o_split_y   (o_split_y),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // origin + dir * t, product floored back to Q16.16, then clamped to 32 bits
    function automatic logic signed [COORD_W-1:0] coord_on_line(
        logic signed [127:0] o, logic signed [127:0] d, logic signed [127:0] t);
        logic signed [127:0] p;
        p = ((d * t) >>> FRAC) + o;
        if (p < SAT_LO) return COORD_MIN;
        if (p > SAT_HI) return COORD_MAX;
        return p[COORD_W-1:0];
    endfunction

    function automatic t_split split_point_of(t_segment sg, t_line ln);
        logic signed [127:0] p1x, p1y, ex, ey, ox, oy, dx, dy;
        logic signed [127:0] den, num, t, dotv, ee;
        t_split r;
        p1x = $signed(sg.p1x);
        p1y = $signed(sg.p1y);
        ex  = $signed(sg.p2x) - p1x;
        ey  = $signed(sg.p2y) - p1y;
        ox  = $signed(ln.ox);
        oy  = $signed(ln.oy);
        dx  = $signed(ln.dx);
        dy  = $signed(ln.dy);
        den = dy * ex - dx * ey;
        r = '0;
        // parallel line or zero-length segment: no hit, point at zero
        if (den == 0) return r;
        num = ((p1y - oy) * ex - (p1x - ox) * ey) <<< FRAC;
        t = num / den;  // signed divide truncates toward zero
        r.sx = coord_on_line(ox, dx, t);
        r.sy = coord_on_line(oy, dy, t);
        // hit test runs on the clamped point
        dotv = ($signed(r.sx) - p1x) * ex + ($signed(r.sy) - p1y) * ey;
        ee = ex * ex + ey * ey;
        r.hit = (dotv >= 0) && (dotv <= ee);
        return r;
    endfunction

    function automatic t_segment mk_seg(logic signed [COORD_W-1:0] ax, ay, bx, by);
        t_segment sg;
        sg.p1x = ax;
        sg.p1y = ay;
        sg.p2x = bx;
        sg.p2y = by;
        return sg;
    endfunction

    function automatic logic signed [COORD_W-1:0] near(int span);
        return $signed(32'($urandom_range(0, 2 * span))) - span;
    endfunction

    function automatic logic signed [COORD_W-1:0] edge_value();
        case ($urandom_range(0, 6))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return 0;
            3: return -1;
            4: return 1;
            5: return ONE;
            default: return $urandom;
        endcase
    endfunction

    // near-origin, line-crossing, parallel, degenerate, edge-value and random segments
    function automatic t_segment random_segment(t_line ln);
        t_segment sg;
        logic signed [COORD_W-1:0] cx, cy, vx, vy, k;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            sg = mk_seg(near(NEAR_SPAN), near(NEAR_SPAN), near(NEAR_SPAN), near(NEAR_SPAN));
        end else if (roll < 55) begin
            sg = mk_seg($urandom, $urandom, $urandom, $urandom);
        end else if (roll < 72) begin
            // straddle a point on the line
            k  = $signed(32'($urandom_range(0, 6))) - 3;
            cx = ln.ox + ln.dx * k;
            cy = ln.oy + ln.dy * k;
            vx = near(1 << 18);
            vy = near(1 << 18);
            sg = mk_seg(cx + vx, cy + vy, cx - vx, cy - vy);
        end else if (roll < 82) begin
            k  = $urandom_range(1, 3);
            cx = near(NEAR_SPAN);
            cy = near(NEAR_SPAN);
            sg = mk_seg(cx, cy, cx + ln.dx * k, cy + ln.dy * k);
        end else if (roll < 87) begin
            cx = $urandom;
            cy = $urandom;
            sg = mk_seg(cx, cy, cx, cy);
        end else begin
            sg = mk_seg(edge_value(), edge_value(), edge_value(), edge_value());
        end
        return sg;
    endfunction

    task automatic queue_segment(t_segment sg);
        segments_pending.insert(segments_pending.size(), sg);
        segments_queued++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic signed [COORD_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_ORIGIN_X: line_now.ox = val;
            CFG_ORIGIN_Y: line_now.oy = val;
            CFG_DIR_X:    line_now.dx = val;
            CFG_DIR_Y:    line_now.dy = val;
        endcase
    endtask

    // only called with the pipeline empty
    task automatic set_line(logic signed [COORD_W-1:0] ox, oy, dx, dy);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_DIR_X, dx);
        write_reg(CFG_DIR_Y, dy);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        line_settings++;
    endtask

    task automatic wait_idle();
        while (splits_checked != segments_queued) @(posedge i_clk);
    endtask

    // sender: bursts with random gaps, and a full drain every so often
    always @(negedge i_clk) begin : drive
        t_segment sg;
        logic go;
        go = start && !seg_taken;
        if (!go) begin
            if (drain_hold) begin
                if (splits_expected.size() == 0) drain_hold = 1'b0;
            end else if (gap_left != 0) begin
                gap_left--;
            end else if (segments_pending.size() != 0) begin
                sg = segments_pending.pop_front();
                go = 1'b1;
                i_p1_x <= sg.p1x;
                i_p1_y <= sg.p1y;
                i_p2_x <= sg.p2x;
                i_p2_y <= sg.p2y;
                segments_sent++;
                if (segments_sent % 193 == 0) drain_hold = 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end else begin
                    burst_left--;
                end
            end
        end
        start <= go;
    end

    always @(posedge i_clk) begin : observe
        t_split want;
        cycles++;
        seg_taken = start && (busy === 1'b0);
        if (seg_taken)
            splits_expected.insert(splits_expected.size(),
                split_point_of(mk_seg(i_p1_x, i_p1_y, i_p2_x, i_p2_y), line_now));
        if (i_rst_n && o_valid !== 1'b0) begin
            if (splits_expected.size() == 0) begin
                $display("%0t: result with none expected: hit %b point (%0d, %0d)",
                         $time, o_hit, o_split_x, o_split_y);
                failures++;
            end else begin
                want = splits_expected.pop_front();
                splits_checked++;
                if (want.hit) hits_seen++;
                if (o_hit !== want.hit) begin
                    $display("%0t: hit expected %b, actual %b", $time, want.hit, o_hit);
                    failures++;
                end
                if (o_split_x !== want.sx) begin
                    $display("%0t: split_x expected %0d, actual %0d", $time, want.sx, o_split_x);
                    failures++;
                end
                if (o_split_y !== want.sy) begin
                    $display("%0t: split_y expected %0d, actual %0d", $time, want.sy, o_split_y);
                    failures++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, segments_queued - splits_checked);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset line is the x axis through the origin
        queue_segment(mk_seg(2 * ONE, -ONE, 2 * ONE, ONE));
        queue_segment(mk_seg(0, ONE, 5 * ONE, ONE));
        queue_segment(mk_seg(3 * ONE, 3 * ONE, 3 * ONE, 3 * ONE));
        queue_segment(mk_seg(ONE, ONE, ONE, 3 * ONE));
        queue_segment(mk_seg(3 * ONE, 0, 3 * ONE, 2 * ONE));
        queue_segment(mk_seg(3 * ONE, -2 * ONE, 3 * ONE, 0));
        queue_segment(mk_seg(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
        queue_segment(mk_seg(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
        queue_segment(mk_seg(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
        queue_segment(mk_seg(0, 0, 0, 0));
        queue_segment(mk_seg(0, COORD_MAX, COORD_MAX, COORD_MAX - 1));
        queue_segment(mk_seg(0, COORD_MAX, COORD_MIN, COORD_MAX - 1));
        queue_segment(mk_seg(0, -1, 1, 2));
        queue_segment(mk_seg(0, -1, -1, 2));
        wait_idle();

        set_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        queue_segment(mk_seg(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
        queue_segment(mk_seg(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN));
        queue_segment(mk_seg(0, 0, ONE, 0));
        queue_segment(mk_seg(COORD_MIN, 0, COORD_MAX, 0));
        wait_idle();

        // zero direction: every segment counts as parallel
        set_line(0, 0, 0, 0);
        queue_segment(mk_seg(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
        queue_segment(mk_seg(ONE, -ONE, ONE, ONE));
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_line(near(NEAR_SPAN), near(NEAR_SPAN), near(1 << 17), near(1 << 17));
                1: set_line(near(NEAR_SPAN), near(NEAR_SPAN), 0, ONE);
                2: set_line(near(NEAR_SPAN), near(NEAR_SPAN), 1, -1);
                3: set_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
                4: set_line(0, near(NEAR_SPAN), ONE, ONE);
                5: set_line($urandom, $urandom, $urandom, $urandom);
                6: set_line(COORD_MIN, COORD_MAX, COORD_MAX, 0);
                default: set_line(near(NEAR_SPAN), near(NEAR_SPAN), near(1 << 17),
                                  near(1 << 17));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) queue_segment(random_segment(line_now));
            wait_idle();
        end

        // catch anything the pipeline emits late
        repeat (LATENCY + 8) @(posedge i_clk);
        if (splits_expected.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, splits_expected.size());
            failures++;
        end

        $display("Ran %0d segments over %0d line settings, %0d of them crossing their line",
                 segments_queued, line_settings + 1, hits_seen);
        $display("Checked %0d results, %0d errors", splits_checked, failures);
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
